>>> sv/md4_compression_reduced_rounds_macros.svh
// Assertion macros shared by the MD4 reduced-round compression RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef MD4_COMPRESSION_REDUCED_ROUNDS_MACROS_SVH
`define MD4_COMPRESSION_REDUCED_ROUNDS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MD4CR_ASSERT_SAME(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("md4cr: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MD4CR_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("md4cr: next-cycle check failed");

`endif

>>> sv/md4cr_pkg.sv
// Package for the MD4 reduced-round compression block: widths, IV, round constants,
// the per-step rotation and message schedule tables and the step helpers. No dependencies.
`default_nettype none

package md4cr_pkg;

    localparam int WORD_W         = 32;
    localparam int ROUND_COUNT_W  = 6;
    localparam int MAX_ROUNDS_DEF = 48;

    typedef logic [WORD_W-1:0]        word_t;
    typedef logic [ROUND_COUNT_W-1:0] round_count_t;

    localparam round_count_t ROUND_COUNT_RST = 6'd48;

    localparam word_t IV_A = 32'h67452301;
    localparam word_t IV_B = 32'hefcdab89;
    localparam word_t IV_C = 32'h98badcfe;
    localparam word_t IV_D = 32'h10325476;

    localparam word_t K_ROUND1 = 32'h00000000;
    localparam word_t K_ROUND2 = 32'h5a827999;
    localparam word_t K_ROUND3 = 32'h6ed9eba1;

    localparam logic [4:0] ROT_AMT [48] = '{
        5'd3, 5'd7, 5'd11, 5'd19, 5'd3, 5'd7, 5'd11, 5'd19,
        5'd3, 5'd7, 5'd11, 5'd19, 5'd3, 5'd7, 5'd11, 5'd19,
        5'd3, 5'd5, 5'd9,  5'd13, 5'd3, 5'd5, 5'd9,  5'd13,
        5'd3, 5'd5, 5'd9,  5'd13, 5'd3, 5'd5, 5'd9,  5'd13,
        5'd3, 5'd9, 5'd11, 5'd15, 5'd3, 5'd9, 5'd11, 5'd15,
        5'd3, 5'd9, 5'd11, 5'd15, 5'd3, 5'd9, 5'd11, 5'd15
    };

    localparam logic [3:0] WORD_SEL [48] = '{
        4'd0, 4'd1, 4'd2,  4'd3,  4'd4, 4'd5, 4'd6,  4'd7,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
        4'd0, 4'd4, 4'd8,  4'd12, 4'd1, 4'd5, 4'd9,  4'd13,
        4'd2, 4'd6, 4'd10, 4'd14, 4'd3, 4'd7, 4'd11, 4'd15,
        4'd0, 4'd8, 4'd4,  4'd12, 4'd2, 4'd10, 4'd6, 4'd14,
        4'd1, 4'd9, 4'd5,  4'd13, 4'd3, 4'd11, 4'd7, 4'd15
    };

    // Working words are held by position in the step sequence: index 0 is A,
    // 1 is D, 2 is C and 3 is B, so step s, when it runs, rewrites index s mod 4.
    typedef struct packed {
        logic [15:0][WORD_W-1:0] msg;
        logic [3:0][WORD_W-1:0]  cv;
        logic [3:0][WORD_W-1:0]  work;
    } stage_t;

    function automatic word_t round_fn(input int step, input word_t x, input word_t y,
                                       input word_t z);
        word_t f;
        if (step < 16) begin
            f = (x & y) | (~x & z);
        end
        else if (step < 32) begin
            f = (x & y) | (x & z) | (y & z);
        end
        else begin
            f = x ^ y ^ z;
        end
        return f;
    endfunction

    function automatic word_t round_const(input int step);
        word_t k;
        if (step < 16) begin
            k = K_ROUND1;
        end
        else if (step < 32) begin
            k = K_ROUND2;
        end
        else begin
            k = K_ROUND3;
        end
        return k;
    endfunction

    function automatic word_t rotl(input word_t x, input logic [4:0] amt);
        logic [2*WORD_W-1:0] dbl;
        dbl = {x, x} << amt;
        return dbl[2*WORD_W-1:WORD_W];
    endfunction

endpackage

`default_nettype wire

>>> sv/md4_compression_reduced_rounds.sv
// MD4 compression of one 512-bit block with a configurable step count, unrolled one step
// per pipeline stage. Depends on md4cr_pkg and md4_compression_reduced_rounds_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) carries sixteen message words as eight 64-bit pairs,
//   the chaining value as chain_ab/chain_cd, and use_standard_iv, which substitutes the
//   standard MD4 initial value for the chaining fields.
//   Output channel (out_valid/out_ready) returns the four feed-forward words as
//   digest_ab and digest_cd, one result item for every input item, in order.
//   Configuration channel (cfg_valid/cfg_ready/cfg_data) writes round_count; cfg_ready
//   is always high. Values above MAX_ROUNDS run MAX_ROUNDS steps; zero runs none.
//   Write it only while no item is in flight.
// Timing:
//   Each stage holds one step; an accepted item moves through the stage registers in order
//   and then into the output register. One item is accepted per cycle while the output
//   is not stalled. Throughput is set by the single shared advance enable of the stage chain.
// Reset and stall:
//   Reset empties the pipeline and sets round_count to 48.
//   While out_valid is high and out_ready is low, the whole pipeline holds and
//   in_ready drops; nothing is lost or repeated. A held result keeps its payload.
`default_nettype none

`include "md4_compression_reduced_rounds_macros.svh"

module md4_compression_reduced_rounds
    import md4cr_pkg::*;
#(
    parameter int MAX_ROUNDS = MAX_ROUNDS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [ROUND_COUNT_W-1:0] cfg_data,

    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [63:0]              msg_pair_0,
    input  wire logic [63:0]              msg_pair_1,
    input  wire logic [63:0]              msg_pair_2,
    input  wire logic [63:0]              msg_pair_3,
    input  wire logic [63:0]              msg_pair_4,
    input  wire logic [63:0]              msg_pair_5,
    input  wire logic [63:0]              msg_pair_6,
    input  wire logic [63:0]              msg_pair_7,
    input  wire logic [63:0]              chain_ab,
    input  wire logic [63:0]              chain_cd,
    input  wire logic                     use_standard_iv,

    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [63:0]                   digest_ab,
    output logic [63:0]                   digest_cd
);

    round_count_t           round_count_reg;
    logic                   advance;
    stage_t                 entry;
    stage_t                 stage_next [MAX_ROUNDS];
    stage_t                 stage_reg  [MAX_ROUNDS];
    logic [MAX_ROUNDS-1:0]  vld_reg;
    logic [MAX_ROUNDS-1:0]  vld_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [63:0]            digest_ab_reg;
    logic [63:0]            digest_cd_reg;
    logic [63:0]            digest_ab_next;
    logic [63:0]            digest_cd_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_count_reg <= ROUND_COUNT_RST;
        end
        else if (cfg_valid)
        begin
            round_count_reg <= cfg_data;
        end
    end

    // The whole chain moves together whenever the output register can take a result.
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    always_comb
    begin
        entry.msg = {msg_pair_7, msg_pair_6, msg_pair_5, msg_pair_4,
                     msg_pair_3, msg_pair_2, msg_pair_1, msg_pair_0};
        if (use_standard_iv)
        begin
            entry.cv = {IV_D, IV_C, IV_B, IV_A};
        end
        else
        begin
            entry.cv = {chain_cd, chain_ab};
        end
        entry.work = {entry.cv[1], entry.cv[2], entry.cv[3], entry.cv[0]};
    end

    for (genvar s = 0; s < MAX_ROUNDS; s++)
    begin : g_step
        localparam int TGT = s % 4;
        localparam int XI  = (s + 3) % 4;
        localparam int YI  = (s + 2) % 4;
        localparam int ZI  = (s + 1) % 4;

        stage_t src;
        word_t  sum;

        if (s == 0)
        begin : g_first
            assign src = entry;
        end
        else
        begin : g_rest
            assign src = stage_reg[s-1];
        end

        always_comb
        begin
            sum = src.work[TGT]
                + round_fn(s, src.work[XI], src.work[YI], src.work[ZI])
                + src.msg[WORD_SEL[s]]
                + round_const(s);
            stage_next[s] = src;
            // Steps past the configured count pass the item through untouched.
            if (ROUND_COUNT_W'(s) < round_count_reg)
            begin
                stage_next[s].work[TGT] = rotl(sum, ROT_AMT[s]);
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                stage_reg[s] <= stage_next[s];
            end
        end
    end

    always_comb
    begin
        vld_next = MAX_ROUNDS'({vld_reg, in_valid});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= vld_next;
        end
    end

    always_comb
    begin
        digest_ab_next[31:0]  = stage_reg[MAX_ROUNDS-1].cv[0] + stage_reg[MAX_ROUNDS-1].work[0];
        digest_ab_next[63:32] = stage_reg[MAX_ROUNDS-1].cv[1] + stage_reg[MAX_ROUNDS-1].work[3];
        digest_cd_next[31:0]  = stage_reg[MAX_ROUNDS-1].cv[2] + stage_reg[MAX_ROUNDS-1].work[2];
        digest_cd_next[63:32] = stage_reg[MAX_ROUNDS-1].cv[3] + stage_reg[MAX_ROUNDS-1].work[1];
        out_valid_next        = vld_reg[MAX_ROUNDS-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            digest_ab_reg <= digest_ab_next;
            digest_cd_reg <= digest_cd_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign digest_ab = digest_ab_reg;
    assign digest_cd = digest_cd_reg;

    `MD4CR_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, vld_reg[0])
    `MD4CR_ASSERT_NEXT(a_stall_holds, !advance, $stable(vld_reg) && $stable(out_valid_reg))
    `MD4CR_ASSERT_NEXT(a_last_reaches_out, vld_reg[MAX_ROUNDS-1] && advance, out_valid_reg)

endmodule

`default_nettype wire
